### design/plidf_pkg.sv
// plidf_pkg: shared types and constants for the positional list unit
// request and response structs, operation and status codes, state encoding
// no dependencies
`timescale 1ns / 1ps

package plidf_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int OP_W         = 2;

    // operation codes carried in the request
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_FIND,
        S_FIND_END,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

endpackage

### design/plidf_ram.sv
// plidf_ram: generic simple dual-port ram, one write and one read port
// read data is registered
// no dependencies
`timescale 1ns / 1ps

module plidf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/positional_list_insert_delete_find_unit.sv
// positional_list_insert_delete_find_unit: bounded sequential list in one ram
// depends on plidf_pkg and plidf_ram
//
// usage
//   request channel (req_valid, req_ready, req): op, 1-based position, value.
//   insert places value at the position (one past the end appends), delete
//   removes the entry at the position, find reports whether the value is live.
//   response channel (rsp_valid, rsp_ready, rsp): status, found, count after
//   the request; exactly one response per request transaction.
//   one request is worked at a time; req_ready is high only in idle.
//   work per request, from acceptance to response valid, with L live entries:
//     insert at p <= L: shift entries L down to p up by one (one ram read and
//     write per shifted entry), then store; append at p = L + 1: store only;
//     delete at p: shift entries after p down by one; find: read and compare
//     each live entry; errors, unused op and empty-list find: none. the worst case
//   is set by walking the entries through the single read port of the entry ram.
//   the response sits in an output register; a new request is taken while
//   it waits, and the next response holds in the final state until the
//   receiver takes the previous one.
//   reset empties the list at once; ram contents need no clearing.

`timescale 1ns / 1ps

module positional_list_insert_delete_find_unit #(
    parameter int CAPACITY = plidf_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plidf_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output plidf_pkg::rsp_t rsp
);

    import plidf_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t               state_reg, state_next;
    logic [CW-1:0]        live_cnt_reg, live_cnt_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    status_t              status_reg, status_next;
    logic                 hit_reg, hit_next;
    logic                 mv_valid_reg, mv_valid_next;
    logic [AW-1:0]        mv_addr_reg, mv_addr_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 put_wr;
    logic                 rd_en;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [VALUE_W-1:0]   ram_wr_data;
    logic [VALUE_W-1:0]   rd_data;
    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        cnt_w;

    // entry store
    plidf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // write port: pending shift move has priority over the value store
    assign ram_wr_en   = mv_valid_reg | put_wr;
    assign ram_wr_addr = mv_valid_reg ? mv_addr_reg : ptr_reg;
    assign ram_wr_data = mv_valid_reg ? rd_data : value_reg;

    assign pos_w = PW'(req.position);
    assign cnt_w = PW'(live_cnt_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_cnt_reg  <= '0;
            mv_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_cnt_reg  <= live_cnt_next;
            mv_valid_reg  <= mv_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        last_reg    <= last_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        mv_addr_reg <= mv_addr_next;
        rsp_reg     <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        live_cnt_next  = live_cnt_reg;
        ptr_next       = ptr_reg;
        last_next      = last_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        hit_next       = hit_reg | (cmp_valid_reg & (rd_data == value_reg));
        mv_valid_next  = 1'b0;
        mv_addr_next   = mv_addr_reg;
        cmp_valid_next = 1'b0;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        rsp_next       = rsp_reg;
        put_wr         = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    value_next  = req.value;
                    hit_next    = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (op_t'(req.op))
                        OP_INSERT:
                        begin
                            priority if (req.position == '0 || pos_w > cnt_w + PW'(1))
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (live_cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                live_cnt_next = live_cnt_reg + CW'(1);
                                if (pos_w <= cnt_w)
                                begin
                                    ptr_next   = AW'(live_cnt_reg - CW'(1));
                                    last_next  = AW'(pos_w - PW'(1));
                                    state_next = S_SHIFT_UP;
                                end
                                else
                                begin
                                    ptr_next   = AW'(pos_w - PW'(1));
                                    state_next = S_PUT;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (req.position == '0 || pos_w > cnt_w)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                live_cnt_next = live_cnt_reg - CW'(1);
                                if (pos_w < cnt_w)
                                begin
                                    ptr_next   = AW'(pos_w);
                                    last_next  = AW'(live_cnt_reg - CW'(1));
                                    state_next = S_SHIFT_DN;
                                end
                            end
                        end
                        OP_FIND:
                        begin
                            if (live_cnt_reg != '0)
                            begin
                                ptr_next   = '0;
                                last_next  = AW'(live_cnt_reg - CW'(1));
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            // move entry ptr up to ptr + 1, from the end down to the position
            S_SHIFT_UP:
            begin
                rd_en         = 1'b1;
                mv_valid_next = 1'b1;
                mv_addr_next  = ptr_reg + AW'(1);
                if (ptr_reg == last_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
            end
            // store the new value once the last move has been written
            S_PUT:
            begin
                if (!mv_valid_reg)
                begin
                    put_wr     = 1'b1;
                    state_next = S_FIN;
                end
            end
            // move entry ptr down to ptr - 1, from the position to the end
            S_SHIFT_DN:
            begin
                rd_en         = 1'b1;
                mv_valid_next = 1'b1;
                mv_addr_next  = ptr_reg - AW'(1);
                if (ptr_reg == last_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            // scan live entries, compare each read value in the cycle after its read
            S_FIND:
            begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                if (ptr_reg == last_reg)
                begin
                    state_next = S_FIND_END;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_FIND_END:
            begin
                state_next = S_FIN;
            end
            // hand the result to the output register when it is free
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.found  = hit_reg;
                    rsp_next.count  = COUNT_W'(live_cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
